@@ rtl/ttsc_pkg.sv @@
`timescale 1ns / 1ps
package ttsc_pkg;

  // screen geometry limits
  localparam int MAX_COLUMNS    = 256;
  localparam int MAX_ROWS       = 64;
  localparam int TAB_STOP       = 8;
  localparam int LINE_WIDTH_MIN = 2;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register indexes, byte address is 4*index
  localparam logic [1:0] REG_LINE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_WINDOW_TOP    = 2'd1;
  localparam logic [1:0] REG_WINDOW_BOTTOM = 2'd2;

  // command queue depth between front and back (2 or more)
  localparam int QUEUE_DEPTH_DEF = 2;

  // register reset values
  localparam logic [8:0] LINE_WIDTH_RST    = 9'd80;
  localparam logic [5:0] WINDOW_TOP_RST    = 6'd0;
  localparam logic [5:0] WINDOW_BOTTOM_RST = 6'd21;

  // character codes
  localparam logic [7:0] CH_TERM     = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CTRL_LIMIT  = 8'd32;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_frame;
    logic       end_of_text;
  } in_data_t;

  typedef struct packed {
    logic [5:0] cell_row;
    logic [7:0] cell_column;
    logic [7:0] cell_char;
    logic       clear_below;
    logic       last_of_run;
  } out_data_t;

  typedef enum logic [2:0] {
    K_PRINT   = 3'd0,
    K_CTRL    = 3'd1,
    K_TAB     = 3'd2,
    K_NEWLINE = 3'd3,
    K_EOT     = 3'd4
  } cmd_kind_t;

  // classified item handed from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic       start;
  } cmd_t;

  // effective window geometry
  typedef struct packed {
    logic [7:0] last_col;
    logic [5:0] win_top;
    logic [5:0] win_bottom;
  } cfg_t;

endpackage

@@ rtl/ttsc_front.sv @@
`timescale 1ns / 1ps
module ttsc_front (
  input  logic              in_valid,
  input  ttsc_pkg::in_data_t in_data,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output ttsc_pkg::cmd_t    q_cmd
);
  import ttsc_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.start = in_data.start_frame;
    q_cmd.ch    = in_data.text_byte;
    if (in_data.end_of_text) begin
      q_cmd.kind = K_EOT;
    end else if (in_data.text_byte == CH_NL) begin
      q_cmd.kind = K_NEWLINE;
    end else if (in_data.text_byte == CH_TAB) begin
      q_cmd.kind = K_TAB;
    end else if (in_data.text_byte < CTRL_LIMIT || in_data.text_byte == CH_DEL) begin
      q_cmd.kind = K_CTRL;
      q_cmd.ch   = in_data.text_byte + CTRL_OFFSET;
    end else begin
      q_cmd.kind = K_PRINT;
    end
  end

endmodule

@@ rtl/ttsc_queue.sv @@
`timescale 1ns / 1ps
module ttsc_queue #(
  parameter int DEPTH = ttsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttsc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output ttsc_pkg::cmd_t pop_cmd
);
  import ttsc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/ttsc_back.sv @@
`timescale 1ns / 1ps
module ttsc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ttsc_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  ttsc_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  output ttsc_pkg::out_data_t out_data,
  input  logic                out_stall
);
  import ttsc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WMARK = 5'b00010,
    ST_WTERM = 5'b00100,
    ST_BODY  = 5'b01000,
    ST_CHAR  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] row_r, row_nxt;
  logic [7:0] col_r, col_nxt;
  logic       full_r, full_nxt;
  logic       mid_r, mid_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_data_t  out_data_r, out_data_nxt;

  logic       out_free, emit;
  out_data_t  cur_cell;
  logic [5:0] row_e;
  logic [7:0] col_e;
  logic       full_e;
  logic       at_bottom, sw_is_max, tab_end, col_next_is_last;

  assign out_free         = !out_valid_r || !out_stall;
  assign at_bottom        = (row_r >= cfg.win_bottom);
  assign sw_is_max        = &cfg.last_col;
  assign col_next_is_last = ((col_r + 8'd1) == cfg.last_col);
  assign tab_end          = ((col_r & 8'(TAB_STOP - 1)) == 8'(TAB_STOP - 1)) || col_next_is_last;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    full_nxt  = full_r;
    mid_nxt   = mid_r;
    cmd_nxt   = cmd_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    cur_cell  = '{cell_row: row_r, cell_column: col_r, cell_char: CH_TERM,
                  clear_below: 1'b0, last_of_run: 1'b1};
    row_e     = cmd_r.start ? cfg.win_top : row_r;
    col_e     = col_r;
    full_e    = full_r;

    case (state_r)
      ST_IDLE: begin
        row_e  = q_cmd.start ? cfg.win_top : row_r;
        col_e  = q_cmd.start ? 8'd0 : col_r;
        full_e = (q_cmd.start ? 1'b0 : full_r) || (row_e > cfg.win_bottom);
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_cmd;
          row_nxt  = row_e;
          col_nxt  = col_e;
          full_nxt = full_e;
          mid_nxt  = 1'b0;
          if (!full_e) begin
            if (q_cmd.kind inside {K_EOT, K_NEWLINE}) begin
              state_nxt = ST_BODY;
            end else if (col_e >= cfg.last_col) begin
              state_nxt = ST_WMARK;
            end else begin
              state_nxt = ST_BODY;
            end
          end
        end
      end
      ST_WMARK: begin
        if (out_free) begin
          emit                 = 1'b1;
          cur_cell.cell_column = cfg.last_col;
          cur_cell.cell_char   = CH_BANG;
          cur_cell.last_of_run = sw_is_max && at_bottom;
          state_nxt            = ST_WTERM;
        end
      end
      ST_WTERM: begin
        if (out_free) begin
          // terminator past column 255 is not painted
          emit                 = !sw_is_max;
          cur_cell.cell_column = cfg.last_col + 8'd1;
          cur_cell.last_of_run = at_bottom;
          col_nxt              = 8'd0;
          if (at_bottom) begin
            full_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            row_nxt   = row_r + 6'd1;
            state_nxt = mid_r ? ST_CHAR : ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (out_free) begin
          emit    = 1'b1;
          col_nxt = col_r + 8'd1;
          case (cmd_r.kind)
            K_EOT: begin
              cur_cell.clear_below = 1'b1;
              col_nxt              = col_r;
              state_nxt            = ST_IDLE;
            end
            K_NEWLINE: begin
              col_nxt   = 8'd0;
              state_nxt = ST_IDLE;
              if (at_bottom) begin
                full_nxt = 1'b1;
              end else begin
                row_nxt = row_r + 6'd1;
              end
            end
            K_TAB: begin
              cur_cell.cell_char   = CH_SPACE;
              cur_cell.last_of_run = tab_end;
              if (tab_end) begin
                state_nxt = ST_IDLE;
              end
            end
            K_CTRL: begin
              cur_cell.cell_char   = CH_CARET;
              cur_cell.last_of_run = 1'b0;
              if (col_next_is_last) begin
                mid_nxt   = 1'b1;
                state_nxt = ST_WMARK;
              end else begin
                state_nxt = ST_CHAR;
              end
            end
            K_PRINT: begin
              cur_cell.cell_char = cmd_r.ch;
              state_nxt          = ST_IDLE;
            end
            default: begin
              emit      = 1'b0;
              col_nxt   = col_r;
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CHAR: begin
        if (out_free) begin
          emit               = 1'b1;
          cur_cell.cell_char = cmd_r.ch;
          col_nxt            = col_r + 8'd1;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = cur_cell;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= WINDOW_TOP_RST;
      col_r       <= 8'd0;
      full_r      <= 1'b0;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      full_r      <= full_nxt;
      mid_r       <= mid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/text_to_screen_cell_layout_unit.sv @@
`timescale 1ns / 1ps
// Text-to-screen cell layout. Text bytes come in one transfer each and leave as
// screen cells (row, column, character): newline ends the row with a zero
// terminator, tab pads with spaces to the next stop of 8 (clipped before the
// last column), control bytes and DEL show as caret plus byte+64, and hitting
// the last column paints '!' and a terminator, then wraps. An end-of-text
// transfer paints a terminator with clear_below set; once the row after the
// window bottom would be needed, every cell is dropped until a start_frame.
// Flow: the front classifies a byte in the cycle it is taken and drops it in
// a small command queue, so input keeps flowing while cells drain until the
// queue fills. The back sequencer takes each item off the queue in a dispatch
// step, then paints its cells (a wrap whose terminator would land past column
// 255 still spends the terminator step unpainted) and finishes an item before
// taking the next. It paints one cell per cycle while out_stall is low and sets
// the rate; a cell held in the output register blocks the next from forming.
// Registers (APB, byte address 4*i): 0 line_width (reset 80), 1 window_top
// (reset 0), 2 window_bottom (reset 21). Write them only while the block is
// idle; a write does not move the cursor.
module text_to_screen_cell_layout_unit #(
  parameter int QUEUE_DEPTH = ttsc_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // text input
  input  logic                                in_valid,
  input  ttsc_pkg::in_data_t                  in_data,
  output logic                                in_stall,
  // cell output
  output logic                                out_valid,
  output ttsc_pkg::out_data_t                 out_data,
  input  logic                                out_stall,
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ttsc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ttsc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ttsc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import ttsc_pkg::*;

  logic [8:0] line_width_r, line_width_nxt;
  logic [5:0] window_top_r, window_top_nxt;
  logic [5:0] window_bottom_r, window_bottom_nxt;

  logic [1:0] reg_idx;
  logic       cfg_wr;
  logic [8:0] width_eff;
  cfg_t       geom;

  logic q_push, q_full, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  // apb: no wait states, write lands on the access cycle
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    line_width_nxt    = line_width_r;
    window_top_nxt    = window_top_r;
    window_bottom_nxt = window_bottom_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_LINE_WIDTH:    line_width_nxt    = cfg_pwdata[8:0];
        REG_WINDOW_TOP:    window_top_nxt    = cfg_pwdata[5:0];
        REG_WINDOW_BOTTOM: window_bottom_nxt = cfg_pwdata[5:0];
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LINE_WIDTH:    cfg_prdata = CFG_DATA_W'(line_width_r);
      REG_WINDOW_TOP:    cfg_prdata = CFG_DATA_W'(window_top_r);
      REG_WINDOW_BOTTOM: cfg_prdata = CFG_DATA_W'(window_bottom_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r    <= LINE_WIDTH_RST;
      window_top_r    <= WINDOW_TOP_RST;
      window_bottom_r <= WINDOW_BOTTOM_RST;
    end else begin
      line_width_r    <= line_width_nxt;
      window_top_r    <= window_top_nxt;
      window_bottom_r <= window_bottom_nxt;
    end
  end

  // clamp the geometry: width into [2, MAX_COLUMNS], bottom to the last row
  always_comb begin
    if (line_width_r < 9'(LINE_WIDTH_MIN)) begin
      width_eff = 9'(LINE_WIDTH_MIN);
    end else if (line_width_r > 9'(MAX_COLUMNS)) begin
      width_eff = 9'(MAX_COLUMNS);
    end else begin
      width_eff = line_width_r;
    end
    geom.last_col = 8'(width_eff - 9'd1);
    geom.win_top  = window_top_r;
    if (window_bottom_r > 6'(MAX_ROWS - 1)) begin
      geom.win_bottom = 6'(MAX_ROWS - 1);
    end else begin
      geom.win_bottom = window_bottom_r;
    end
  end

  // front: classify each byte into a command
  ttsc_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // command queue decouples intake from cell generation
  ttsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  // back: cursor state and one cell per cycle into the output register while it is free
  ttsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (geom),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

@@ rtl/ttsc_checker.sv @@
`timescale 1ns / 1ps
module ttsc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input ttsc_pkg::out_data_t out_data
);
  import ttsc_pkg::*;

  // a stalled cell stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output cell changed while stalled");

  // reset empties the output register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // end-of-text cell is a lone terminator closing its run
  a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clear_below |-> out_data.last_of_run)
    else $error("clear_below cell not last of run");

  a_eot_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clear_below |-> out_data.cell_char == CH_TERM)
    else $error("clear_below cell is not a terminator");

endmodule

bind text_to_screen_cell_layout_unit ttsc_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
